### sv/lpht_pkg.sv
`default_nettype none
package lpht_pkg;

  localparam int SLOTS      = 16;
  localparam int KEY_BYTES  = 8;
  localparam int COUNT_BITS = 16;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int KEY_W  = 64;
  localparam int HASH_W = 32;
  // hash and modulo phases both run eight steps: eight key bytes, eight hash nibbles
  localparam int STEP_W = 3;
  localparam int NIB_W  = 4;
  localparam int MOD_W  = SLOT_W + NIB_W + 1;

  localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
  localparam int HASH_SHIFT = 5;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  localparam logic [1:0] FN_ADD    = 2'd0;
  localparam logic [1:0] FN_LOOKUP = 2'd1;
  localparam logic [1:0] FN_REMOVE = 2'd2;

  localparam logic [1:0] MARK_FREE    = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
  } in_word_t;

  typedef struct packed {
    logic [15:0] count;
    logic [1:0]  status;
    logic [3:0]  slot;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_MOD,
    S_ISSUE,
    S_PROBE,
    S_COMMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic mod_step;
    logic probe_issue;
    logic probe_step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic probe_done;
  } sts_t;

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] p);
    logic [SLOT_W-1:0] r;
    if (p == SLOT_W'(SLOTS - 1)) begin
      r = '0;
    end else begin
      r = p + SLOT_W'(1);
    end
    return r;
  endfunction

endpackage
`default_nettype wire

### sv/lpht_ctrl.sv
`default_nettype none
module lpht_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire lpht_pkg::sts_t sts,
  output lpht_pkg::cmd_t     cmd
);

  lpht_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lpht_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lpht_pkg::S_IDLE:   if (in_valid) state_nxt = lpht_pkg::S_HASH;
      lpht_pkg::S_HASH:   if (sts.step_last) state_nxt = lpht_pkg::S_MOD;
      lpht_pkg::S_MOD:    if (sts.step_last) state_nxt = lpht_pkg::S_ISSUE;
      lpht_pkg::S_ISSUE:  state_nxt = lpht_pkg::S_PROBE;
      lpht_pkg::S_PROBE:  if (sts.probe_done) state_nxt = lpht_pkg::S_COMMIT;
      lpht_pkg::S_COMMIT: if (out_free) state_nxt = lpht_pkg::S_IDLE;
      default:            state_nxt = lpht_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      lpht_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      lpht_pkg::S_HASH:   cmd.hash_step = 1'b1;
      lpht_pkg::S_MOD:    cmd.mod_step = 1'b1;
      lpht_pkg::S_ISSUE:  cmd.probe_issue = 1'b1;
      lpht_pkg::S_PROBE:  cmd.probe_step = 1'b1;
      lpht_pkg::S_COMMIT: cmd.commit = out_free;
      default:            cmd = '0;
    endcase
  end

  // result word register stays full until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

### sv/lpht_dp.sv
`default_nettype none
module lpht_dp (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire lpht_pkg::in_word_t  in_data,
  input  wire lpht_pkg::cmd_t      cmd,
  output lpht_pkg::sts_t           sts,
  output lpht_pkg::out_word_t      out_data
);

  localparam int SW = lpht_pkg::SLOT_W;
  localparam int CW = lpht_pkg::COUNT_BITS;
  localparam int KW = lpht_pkg::KEY_W;
  localparam int HW = lpht_pkg::HASH_W;
  localparam int MW = lpht_pkg::MOD_W;

  // working registers of one word
  logic [1:0]                  func_r;
  logic [KW-1:0]               key_r;
  logic [KW-1:0]               nkey_r;
  logic [HW-1:0]               hash_r;
  logic                        ended_r;
  logic [lpht_pkg::STEP_W-1:0] step_r;
  logic [SW-1:0]               rem_r;
  logic [SW-1:0]               p_r;
  logic [SW-1:0]               vcnt_r;
  logic                        found_r;
  logic [SW-1:0]               fpos_r;
  logic [CW-1:0]               fcnt_r;
  logic                        ins_ok_r;
  logic [SW-1:0]               ins_at_r;
  lpht_pkg::out_word_t         out_data_r;

  // slot storage
  logic [1:0]    mark_r [lpht_pkg::SLOTS];
  logic [KW-1:0] key_mem [lpht_pkg::SLOTS];
  logic [CW-1:0] cnt_mem [lpht_pkg::SLOTS];
  logic [1:0]    rd_mark_r;
  logic [KW-1:0] rd_key_r;
  logic [CW-1:0] rd_cnt_r;
  logic [SW-1:0] rd_addr_r;

  logic [7:0]    byte_raw;
  logic [7:0]    byte_eff;
  logic [HW-1:0] hash_nxt;
  logic [MW-1:0] mod_acc;
  logic [SW-1:0] rem_nxt;
  logic [SW-1:0] rd_addr;
  logic          rd_en;
  logic          is_free;
  logic          is_used;
  logic          is_match;
  logic          visit_last;

  logic          we_cnt;
  logic          we_key;
  logic          we_mark;
  logic [1:0]    wr_mark;
  logic [SW-1:0] wr_addr;
  logic [CW-1:0] wr_cnt;
  lpht_pkg::out_word_t res;

  // djb2 step, zero byte or byte beyond the key length ends the key
  always_comb begin
    byte_raw = key_r[7:0];
    if (ended_r || (int'(step_r) >= lpht_pkg::KEY_BYTES)) begin
      byte_eff = 8'd0;
    end else begin
      byte_eff = byte_raw;
    end
    if (byte_eff != 8'd0) begin
      hash_nxt = (hash_r << lpht_pkg::HASH_SHIFT) + hash_r + HW'(byte_eff);
    end else begin
      hash_nxt = hash_r;
    end
  end

  // one nibble of restoring remainder per step, hash msb first
  always_comb begin
    mod_acc = {1'b0, rem_r, hash_r[HW-1 -: lpht_pkg::NIB_W]};
    for (int i = lpht_pkg::NIB_W - 1; i >= 0; i--) begin
      if (mod_acc >= (MW'(lpht_pkg::SLOTS) << i)) begin
        mod_acc = mod_acc - (MW'(lpht_pkg::SLOTS) << i);
      end
    end
    rem_nxt = mod_acc[SW-1:0];
  end

  assign rd_addr = cmd.probe_issue ? rem_r : p_r;
  assign rd_en   = cmd.probe_issue || cmd.probe_step;

  assign is_free    = (rd_mark_r == lpht_pkg::MARK_FREE);
  assign is_used    = (rd_mark_r == lpht_pkg::MARK_USED);
  assign is_match   = is_used && (rd_key_r == nkey_r);
  assign visit_last = (vcnt_r == SW'(lpht_pkg::SLOTS - 1));

  assign sts.step_last  = (step_r == {lpht_pkg::STEP_W{1'b1}});
  assign sts.probe_done = cmd.probe_step && (is_free || is_match || visit_last);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_data.func;
      key_r   <= in_data.key;
      nkey_r  <= '0;
      hash_r  <= lpht_pkg::HASH_SEED;
      ended_r <= 1'b0;
      step_r  <= '0;
      rem_r   <= '0;
    end
    if (cmd.hash_step) begin
      hash_r  <= hash_nxt;
      ended_r <= ended_r || (byte_eff == 8'd0);
      key_r   <= key_r >> 8;
      nkey_r  <= {byte_eff, nkey_r[KW-1:8]};
      step_r  <= step_r + lpht_pkg::STEP_W'(1);
    end
    if (cmd.mod_step) begin
      rem_r  <= rem_nxt;
      hash_r <= hash_r << lpht_pkg::NIB_W;
      step_r <= step_r + lpht_pkg::STEP_W'(1);
    end
    if (cmd.probe_issue) begin
      p_r      <= lpht_pkg::slot_inc(rem_r);
      vcnt_r   <= '0;
      found_r  <= 1'b0;
      ins_ok_r <= 1'b0;
    end
    if (cmd.probe_step) begin
      p_r    <= lpht_pkg::slot_inc(p_r);
      vcnt_r <= vcnt_r + SW'(1);
      if (!ins_ok_r && !is_used) begin
        ins_ok_r <= 1'b1;
        ins_at_r <= rd_addr_r;
      end
      if (is_match) begin
        found_r <= 1'b1;
        fpos_r  <= rd_addr_r;
        fcnt_r  <= rd_cnt_r;
      end
    end
    if (cmd.commit) begin
      out_data_r <= res;
    end
  end

  // result and write-back of the operation
  always_comb begin
    res        = '0;
    res.status = lpht_pkg::ST_OK;
    wr_addr    = fpos_r;
    wr_cnt     = fcnt_r;
    wr_mark    = lpht_pkg::MARK_USED;
    we_cnt     = 1'b0;
    we_key     = 1'b0;
    we_mark    = 1'b0;
    unique case (func_r)
      lpht_pkg::FN_ADD: begin
        if (found_r) begin
          wr_cnt    = (fcnt_r == lpht_pkg::CNT_MAX) ? fcnt_r : fcnt_r + CW'(1);
          we_cnt    = 1'b1;
          res.count = 16'(wr_cnt);
          res.slot  = 4'(fpos_r);
        end else if (ins_ok_r) begin
          wr_addr   = ins_at_r;
          wr_cnt    = CW'(1);
          we_cnt    = 1'b1;
          we_key    = 1'b1;
          we_mark   = 1'b1;
          res.count = 16'(wr_cnt);
          res.slot  = 4'(ins_at_r);
        end else begin
          res.status = lpht_pkg::ST_FULL;
        end
      end
      lpht_pkg::FN_REMOVE: begin
        if (found_r) begin
          wr_cnt    = (fcnt_r == '0) ? fcnt_r : fcnt_r - CW'(1);
          we_cnt    = 1'b1;
          if (wr_cnt == '0) begin
            we_mark = 1'b1;
            wr_mark = lpht_pkg::MARK_DELETED;
          end
          res.count = 16'(wr_cnt);
          res.slot  = 4'(fpos_r);
        end else begin
          res.status = lpht_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        if (found_r) begin
          res.count = 16'(fcnt_r);
          res.slot  = 4'(fpos_r);
        end else begin
          res.status = lpht_pkg::ST_NOT_FOUND;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lpht_pkg::SLOTS; i++) begin
        mark_r[i] <= lpht_pkg::MARK_FREE;
      end
    end else if (cmd.commit && we_mark) begin
      mark_r[wr_addr] <= wr_mark;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_mark_r <= mark_r[rd_addr];
      rd_key_r  <= key_mem[rd_addr];
      rd_cnt_r  <= cnt_mem[rd_addr];
      rd_addr_r <= rd_addr;
    end
    if (cmd.commit && we_key) begin
      key_mem[wr_addr] <= nkey_r;
    end
    if (cmd.commit && we_cnt) begin
      cnt_mem[wr_addr] <= wr_cnt;
    end
  end

  assign out_data = out_data_r;

endmodule
`default_nettype wire

### sv/linear_probe_counting_hash_table.sv
// channel | ports                          | word
// in      | in_valid, in_ready, in_data    | func, key
// out     | out_valid, out_ready, out_data | count, status, slot
//
// one word at a time: accept, hash steps, modulo steps, read issue, then probe reads
// until a free slot, a match or every slot is seen, then the commit
// the probe reads one slot per cycle from the slot memories
// reset marks every slot free at once, no clearing pass
// a waiting result holds the commit, and no next word is accepted until the commit
`default_nettype none
module linear_probe_counting_hash_table (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire lpht_pkg::in_word_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output lpht_pkg::out_word_t      out_data
);

  lpht_pkg::cmd_t cmd;
  lpht_pkg::sts_t sts;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lpht_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

`ifndef SYNTHESIS
  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit over an untaken result");

  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second word accepted while one is in progress");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid)
    else $error("commit did not present a result");

  a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.status == lpht_pkg::ST_FULL))
      |-> (out_data.count == 16'd0 && out_data.slot == 4'd0))
    else $error("table full result carries a count or slot");
`endif

endmodule
`default_nettype wire

### sim/linear_probe_counting_hash_table_test.sv
`default_nettype none
module linear_probe_counting_hash_table_test;

  localparam logic [1:0] FN_SPARE = 2'd3;
  localparam logic [31:0] DJB2_SEED = 32'd5381;
  localparam logic [lpht_pkg::COUNT_BITS-1:0] COUNT_TOP = '1;
  localparam int POOL = 24;
  localparam int RANDOM_WORDS = 1500;
  localparam int QUIET_LIMIT = 4000;
  localparam int TAIL_CYCLES = 80;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_WAVE} rx_style_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  lpht_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  lpht_pkg::out_word_t out_data;

  // predicted table contents
  logic [1:0] tbl_mark [lpht_pkg::SLOTS];
  logic [63:0] tbl_key [lpht_pkg::SLOTS];
  logic [lpht_pkg::COUNT_BITS-1:0] tbl_count [lpht_pkg::SLOTS];

  lpht_pkg::out_word_t answer_q [$];
  lpht_pkg::out_word_t want_now;
  logic [63:0] key_pool [POOL];
  int mismatches = 0;
  int burst_left = 0;
  rx_style_t rx_style = RX_OPEN;
  logic [7:0] rx_left = '0;

  linear_probe_counting_hash_table u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // key bytes up to the first zero byte, plus their djb2 hash
  function automatic logic [63:0] trim_key(input logic [63:0] raw, output logic [31:0] h);
    logic [63:0] k;
    logic [7:0] b;
    bit stop;
    h = DJB2_SEED;
    k = '0;
    stop = 1'b0;
    for (int i = 0; i < lpht_pkg::KEY_BYTES && i < 8; i++) begin
      b = raw[8*i +: 8];
      if (b == 8'h00) stop = 1'b1;
      if (!stop) begin
        h = (h << 5) + h + 32'(b);
        k[8*i +: 8] = b;
      end
    end
    return k;
  endfunction

  function automatic void clear_table();
    for (int i = 0; i < lpht_pkg::SLOTS; i++) begin
      tbl_mark[i] = lpht_pkg::MARK_FREE;
      tbl_key[i] = '0;
      tbl_count[i] = '0;
    end
  endfunction

  // applies one word to the predicted table and gives the answer it should produce
  function automatic lpht_pkg::out_word_t tally_step(input lpht_pkg::in_word_t w);
    logic [31:0] h;
    logic [63:0] k;
    int p, hit, spot;
    bit done;
    lpht_pkg::out_word_t r;
    k = trim_key(w.key, h);
    p = int'(h % lpht_pkg::SLOTS);
    hit = -1;
    spot = -1;
    done = 1'b0;
    for (int v = 0; v < lpht_pkg::SLOTS; v++) begin
      if (!done) begin
        if (tbl_mark[p] == lpht_pkg::MARK_FREE) begin
          if (spot < 0) spot = p;
          done = 1'b1;
        end else if (tbl_mark[p] == lpht_pkg::MARK_USED) begin
          if (tbl_key[p] == k) begin
            hit = p;
            done = 1'b1;
          end
        end else if (spot < 0) begin
          spot = p;
        end
        p = (p + 1) % lpht_pkg::SLOTS;
      end
    end
    r = '0;
    r.status = lpht_pkg::ST_OK;
    case (w.func)
      lpht_pkg::FN_ADD: begin
        if (hit >= 0) begin
          if (tbl_count[hit] != COUNT_TOP) tbl_count[hit] = tbl_count[hit] + 1'b1;
          r.count = 16'(tbl_count[hit]);
          r.slot = 4'(hit);
        end else if (spot >= 0) begin
          tbl_mark[spot] = lpht_pkg::MARK_USED;
          tbl_key[spot] = k;
          tbl_count[spot] = lpht_pkg::COUNT_BITS'(1);
          r.count = 16'd1;
          r.slot = 4'(spot);
        end else begin
          r.status = lpht_pkg::ST_FULL;
        end
      end
      lpht_pkg::FN_REMOVE: begin
        if (hit >= 0) begin
          if (tbl_count[hit] != 0) tbl_count[hit] = tbl_count[hit] - 1'b1;
          if (tbl_count[hit] == 0) tbl_mark[hit] = lpht_pkg::MARK_DELETED;
          r.count = 16'(tbl_count[hit]);
          r.slot = 4'(hit);
        end else begin
          r.status = lpht_pkg::ST_NOT_FOUND;
        end
      end
      default: begin
        if (hit >= 0) begin
          r.count = 16'(tbl_count[hit]);
          r.slot = 4'(hit);
        end else begin
          r.status = lpht_pkg::ST_NOT_FOUND;
        end
      end
    endcase
    return r;
  endfunction

  // fills the bytes above the terminator with noise
  function automatic logic [63:0] dress_key(input logic [63:0] k);
    logic [63:0] noise, r;
    bit past;
    noise = {$urandom, $urandom};
    r = k;
    past = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (past) r[8*i +: 8] = noise[8*i +: 8];
      if (k[8*i +: 8] == 8'h00) past = 1'b1;
    end
    return r;
  endfunction

  task automatic send_word(input logic [1:0] f, input logic [63:0] k,
                           output lpht_pkg::out_word_t want);
    lpht_pkg::in_word_t w;
    int gap;
    w.func = f;
    w.key = k;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 24);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (!in_ready);
    want = tally_step(w);
    answer_q.push_back(want);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (answer_q.size() != 0);
  endtask

  task automatic build_key_pool();
    logic [31:0] h;
    logic [63:0] cand;
    int len;
    bit clash;
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL; i++) begin
      do begin
        cand = '0;
        len = ($urandom_range(0, 2) == 0) ? 8 : $urandom_range(1, 7);
        for (int b = 0; b < len; b++) cand[8*b +: 8] = 8'($urandom_range(1, 255));
        clash = 1'b0;
        for (int j = 0; j < i; j++) begin
          if (trim_key(key_pool[j], h) == trim_key(cand, h)) clash = 1'b1;
        end
      end while (clash);
      key_pool[i] = cand;
    end
  endtask

  task automatic test_key_forms();
    lpht_pkg::out_word_t r;
    send_word(lpht_pkg::FN_ADD, dress_key(key_pool[0]), r);
    send_word(lpht_pkg::FN_ADD, dress_key(key_pool[0]), r);
    send_word(lpht_pkg::FN_LOOKUP, 64'h0, r);
    send_word(lpht_pkg::FN_REMOVE, dress_key(key_pool[0]), r);
    // down to zero leaves a deleted mark
    send_word(lpht_pkg::FN_REMOVE, 64'hFFFF_FFFF_FFFF_FF00, r);
    send_word(lpht_pkg::FN_LOOKUP, key_pool[0], r);
    send_word(lpht_pkg::FN_REMOVE, key_pool[0], r);
    send_word(lpht_pkg::FN_ADD, key_pool[1], r);
    send_word(FN_SPARE, key_pool[1], r);
    send_word(lpht_pkg::FN_ADD, key_pool[0], r);
  endtask

  task automatic test_table_full();
    lpht_pkg::out_word_t r;
    int i;
    i = 2;
    do begin
      send_word(lpht_pkg::FN_ADD, dress_key(key_pool[i]), r);
      i++;
    end while (r.status != lpht_pkg::ST_FULL && i < POOL);
    send_word(lpht_pkg::FN_ADD, key_pool[POOL-1], r);
    send_word(lpht_pkg::FN_LOOKUP, {$urandom, $urandom} | 64'h1, r);
    send_word(lpht_pkg::FN_REMOVE, {$urandom, $urandom} | 64'h1, r);
    send_word(lpht_pkg::FN_LOOKUP, key_pool[3], r);
  endtask

  task automatic test_random_traffic();
    lpht_pkg::out_word_t r;
    int mix, pick, add_pct, rem_pct;
    logic [1:0] f;
    logic [63:0] k;
    add_pct = 50;
    rem_pct = 30;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 100 == 0) begin
        mix = $urandom_range(0, 2);
        add_pct = (mix == 0) ? 60 : (mix == 1) ? 25 : 40;
        rem_pct = (mix == 0) ? 20 : (mix == 1) ? 55 : 30;
      end
      pick = $urandom_range(0, 99);
      if (pick < add_pct) f = lpht_pkg::FN_ADD;
      else if (pick < add_pct + rem_pct) f = lpht_pkg::FN_REMOVE;
      else if (pick < 96) f = lpht_pkg::FN_LOOKUP;
      else f = FN_SPARE;
      // unknown keys only on words that cannot store them
      if (f != lpht_pkg::FN_ADD && $urandom_range(0, 6) == 0) k = {$urandom, $urandom};
      else k = dress_key(key_pool[$urandom_range(0, POOL-1)]);
      send_word(f, k, r);
    end
  endtask

  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_style <= rx_style_t'($urandom_range(0, 3));
      rx_left <= 8'($urandom_range(10, 150));
    end else begin
      rx_left <= rx_left - 1'b1;
    end
    case (rx_style)
      RX_OPEN: out_ready <= 1'b1;
      RX_COIN: out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
      default: out_ready <= rx_left[3];
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (answer_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %p", $time, out_data);
        mismatches++;
      end else begin
        want_now = answer_q.pop_front();
        if (out_data.count !== want_now.count) begin
          $display("%0t: count expected %0d actual %0d", $time, want_now.count, out_data.count);
          mismatches++;
        end
        if (out_data.status !== want_now.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want_now.status,
                   out_data.status);
          mismatches++;
        end
        if (out_data.slot !== want_now.slot) begin
          $display("%0t: slot expected %0d actual %0d", $time, want_now.slot, out_data.slot);
          mismatches++;
        end
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
    $display("tb: failure");
    $finish;
  end

  initial begin
    clear_table();
    build_key_pool();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_key_forms();
    wait_drained();
    test_table_full();
    wait_drained();
    test_random_traffic();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
`default_nettype wire

### linear_probe_counting_hash_table.f
sv/lpht_pkg.sv
sv/lpht_ctrl.sv
sv/lpht_dp.sv
sv/linear_probe_counting_hash_table.sv
sim/linear_probe_counting_hash_table_test.sv
